// ----- hdl/radar_guard_zone_counter_defines.svh -----
// Assertion macros for the radar guard zone counter.
// Both forms expect a clock named aclk and an active-low reset named aresetn.
`ifndef RADAR_GUARD_ZONE_COUNTER_DEFINES_SVH
`define RADAR_GUARD_ZONE_COUNTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define RGZ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("guard zone assertion failed");

// Next-cycle implication.
`define RGZ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("guard zone assertion failed");

`else

`define RGZ_ASSERT_NOW(label, ante, cons)
`define RGZ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- hdl/rgz_pkg.sv -----
package rgz_pkg;

    localparam int LANES      = 4;
    localparam int BINS       = 512;
    localparam int BEARING_W  = 11;
    localparam int FIRST_W    = 9;
    localparam int AMP_W      = 8;
    localparam int BIN_W      = 10;
    localparam int LANE_BIN_W = 10;
    localparam int RUN_W      = 21;
    localparam int BOGEY_W    = 22;
    localparam int HIT_CNT_W  = $clog2(LANES + 1);

    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 24;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] REG_ZONE_ENABLE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ZONE_MODE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_BEARING = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_END_BEARING   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INNER_BIN     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTER_BIN     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_AMP_THRESHOLD = 3'd6;

    localparam logic MODE_ARC    = 1'b0;
    localparam logic MODE_CIRCLE = 1'b1;

    localparam logic [AMP_W-1:0]   THRESHOLD_RESET = 8'd50;
    localparam logic [BIN_W-1:0]   LAST_BIN        = BIN_W'(BINS - 1);
    localparam logic [RUN_W-1:0]   RUN_MAX         = {RUN_W{1'b1}};
    localparam logic [BOGEY_W-1:0] BOGEY_NONE      = {BOGEY_W{1'b1}};

    typedef struct packed {
        logic [BIN_W-1:0] inner;
        logic [BIN_W-1:0] hi;
        logic [AMP_W-1:0] threshold;
    } window_t;

    typedef struct packed {
        logic mode;
        logic inner_ok;
    } zone_t;

    typedef struct packed {
        logic [LANES-1:0]     hits;
        logic [BEARING_W-1:0] bearing;
        logic                 eos;
        logic                 arc_active;
    } stage_t;

endpackage

// ----- hdl/radar_guard_zone_counter.sv -----
// Radar guard zone counter.
// Input stream s_*: one request per cycle while not stalled, each carrying four amplitude lanes of one
// spoke (bins first_bin..first_bin+3), the bearing, and tlast on the last request of
// the spoke. Each lane compares its bin against the zone window and its amplitude
// against the threshold; a merge stage adds the lane hits into the running count.
// Result stream m_*: one request per spoke end while the zone is enabled, carrying
// the latched zone count (-1 until a pass completes) and a flag on tuser that is set
// when this spoke end latched a new count.
// Throughput: one input request every cycle unless a spoke end waits on a stalled receiver.
// Latency: two register stages; a spoke end passes the stage register and then the output
// register before it shows on m_tvalid.
// A stalled receiver holds a spoke end in the stage register and the input behind it; other
// requests keep flowing while a result waits in the output register.
// Configuration: cfg_valid/cfg_index/cfg_data, always ready; a write to any listed
// register also clears the counting state. Write only while the block is idle.
// Reset (aresetn low, synchronous) disables the zone, sets the threshold to 50 and
// the zone count to -1.
module radar_guard_zone_counter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rgz_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rgz_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // bearing[10:0], first_bin[19:11], amp_lane0[27:20], amp_lane1[35:28],
    // amp_lane2[43:36], amp_lane3[51:44], zero pad [55:52]
    input  logic [rgz_pkg::S_TDATA_W-1:0]     s_tdata,
    // end_of_spoke
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // zone_count[21:0], zero pad [23:22]
    output logic [rgz_pkg::M_TDATA_W-1:0]     m_tdata,
    // count_updated
    output logic                              m_tuser
);

    localparam int BO = 0;
    localparam int FO = BO + rgz_pkg::BEARING_W;
    localparam int AO = FO + rgz_pkg::FIRST_W;

    logic                          enable_reg;
    logic                          mode_reg;
    logic [rgz_pkg::BEARING_W-1:0] start_reg;
    logic [rgz_pkg::BEARING_W-1:0] end_reg;
    logic [rgz_pkg::BIN_W-1:0]     inner_reg;
    logic [rgz_pkg::BIN_W-1:0]     outer_reg;
    logic [rgz_pkg::AMP_W-1:0]     threshold_reg;

    logic                          cfg_write;
    logic                          cfg_clear;
    rgz_pkg::window_t              window;
    rgz_pkg::zone_t                zone;

    logic [rgz_pkg::BEARING_W-1:0] in_bearing;
    logic [rgz_pkg::FIRST_W-1:0]   in_first;
    logic                          arc_hit;
    logic                          counting;
    logic [rgz_pkg::LANES-1:0]     lane_hit;

    logic                          s1_valid_reg, s1_valid_next;
    rgz_pkg::stage_t               s1_reg, s1_next;
    logic                          stage_ready;
    logic                          in_accept;

    // configuration registers
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_clear = cfg_write && (cfg_index <= rgz_pkg::REG_AMP_THRESHOLD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            mode_reg      <= rgz_pkg::MODE_ARC;
            start_reg     <= '0;
            end_reg       <= '0;
            inner_reg     <= '0;
            outer_reg     <= '0;
            threshold_reg <= rgz_pkg::THRESHOLD_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                rgz_pkg::REG_ZONE_ENABLE:   enable_reg    <= cfg_data[0];
                rgz_pkg::REG_ZONE_MODE:     mode_reg      <= cfg_data[0];
                rgz_pkg::REG_START_BEARING: start_reg     <= cfg_data[rgz_pkg::BEARING_W-1:0];
                rgz_pkg::REG_END_BEARING:   end_reg       <= cfg_data[rgz_pkg::BEARING_W-1:0];
                rgz_pkg::REG_INNER_BIN:     inner_reg     <= cfg_data[rgz_pkg::BIN_W-1:0];
                rgz_pkg::REG_OUTER_BIN:     outer_reg     <= cfg_data[rgz_pkg::BIN_W-1:0];
                rgz_pkg::REG_AMP_THRESHOLD: threshold_reg <= cfg_data[rgz_pkg::AMP_W-1:0];
                default: ;
            endcase
        end
    end

    assign window.inner     = inner_reg;
    assign window.hi        = (outer_reg > rgz_pkg::LAST_BIN) ? rgz_pkg::LAST_BIN : outer_reg;
    assign window.threshold = threshold_reg;
    assign zone.mode        = mode_reg;
    assign zone.inner_ok    = int'(inner_reg) < rgz_pkg::BINS;

    // lane stage
    assign in_bearing = s_tdata[FO-1:BO];
    assign in_first   = s_tdata[AO-1:FO];

    // start equal to end covers the whole circle
    assign arc_hit = ((in_bearing >= start_reg) && (in_bearing < end_reg))
                     || ((start_reg >= end_reg)
                         && ((in_bearing >= start_reg) || (in_bearing < end_reg)));
    assign counting = (mode_reg == rgz_pkg::MODE_ARC) ? (arc_hit && zone.inner_ok)
                                                      : zone.inner_ok;

    for (genvar l = 0; l < rgz_pkg::LANES; l++) begin : g_lane
        rgz_lane u_lane (
            .window   (window),
            .bin      (rgz_pkg::LANE_BIN_W'(in_first) + rgz_pkg::LANE_BIN_W'(l)),
            .amp      (s_tdata[AO + l*rgz_pkg::AMP_W +: rgz_pkg::AMP_W]),
            .counting (counting),
            .hit      (lane_hit[l])
        );
    end

    assign s_tready  = !s1_valid_reg || stage_ready;
    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        s1_next            = s1_reg;
        s1_valid_next      = s1_valid_reg && !stage_ready;
        if (in_accept) begin
            s1_next.hits       = lane_hit;
            s1_next.bearing    = in_bearing;
            s1_next.eos        = s_tlast;
            s1_next.arc_active = arc_hit;
            // requests taken while disabled leave no trace
            s1_valid_next      = enable_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg <= s1_next;
    end

    rgz_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear       (cfg_clear),
        .zone        (zone),
        .s1_valid    (s1_valid_reg),
        .s1          (s1_reg),
        .stage_ready (stage_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ----- hdl/rgz_lane.sv -----
module rgz_lane (
    input  rgz_pkg::window_t                 window,
    input  logic [rgz_pkg::LANE_BIN_W-1:0]   bin,
    input  logic [rgz_pkg::AMP_W-1:0]        amp,
    input  logic                             counting,
    output logic                             hit
);

    logic [rgz_pkg::LANE_BIN_W-1:0] inner_ext;
    logic [rgz_pkg::LANE_BIN_W-1:0] hi_ext;

    assign inner_ext = rgz_pkg::LANE_BIN_W'(window.inner);
    assign hi_ext    = rgz_pkg::LANE_BIN_W'(window.hi);

    assign hit = counting && (bin >= inner_ext) && (bin <= hi_ext)
                 && (amp >= window.threshold);

endmodule

// ----- hdl/rgz_merge.sv -----
`include "radar_guard_zone_counter_defines.svh"

module rgz_merge (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            clear,
    input  rgz_pkg::zone_t                  zone,
    input  logic                            s1_valid,
    input  rgz_pkg::stage_t                 s1,
    output logic                            stage_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // zone_count[21:0], zero pad [23:22]
    output logic [rgz_pkg::M_TDATA_W-1:0]   m_tdata,
    // count_updated
    output logic                            m_tuser
);

    logic [rgz_pkg::RUN_W-1:0]     running_count_reg, running_count_next;
    logic [rgz_pkg::BOGEY_W-1:0]   latched_count_reg, latched_count_next;
    logic                          was_in_zone_reg, was_in_zone_next;
    logic [rgz_pkg::BEARING_W-1:0] prev_bearing_reg, prev_bearing_next;
    logic                          out_valid_reg, out_valid_next;
    logic [rgz_pkg::BOGEY_W-1:0]   out_count_reg, out_count_next;
    logic                          out_updated_reg, out_updated_next;

    logic [rgz_pkg::HIT_CNT_W-1:0] hit_cnt;
    logic [rgz_pkg::RUN_W:0]       sum;
    logic [rgz_pkg::RUN_W-1:0]     sat_count;
    logic                          active;
    logic                          fire;

    always_comb begin
        hit_cnt = '0;
        for (int l = 0; l < rgz_pkg::LANES; l++) begin
            hit_cnt = hit_cnt + rgz_pkg::HIT_CNT_W'(s1.hits[l]);
        end
    end

    assign sum       = {1'b0, running_count_reg} + (rgz_pkg::RUN_W + 1)'(hit_cnt);
    assign sat_count = (sum > {1'b0, rgz_pkg::RUN_MAX}) ? rgz_pkg::RUN_MAX
                                                         : sum[rgz_pkg::RUN_W-1:0];

    // circle mode: active while the bearing steps upward, so a bearing wrap ends a pass
    assign active = (zone.mode == rgz_pkg::MODE_ARC) ? s1.arc_active
                    : (zone.inner_ok && (s1.bearing > prev_bearing_reg));

    // a spoke end needs room in the output register, other items never wait
    assign stage_ready = !s1.eos || !out_valid_reg || m_tready;
    assign fire        = s1_valid && stage_ready;

    always_comb begin
        running_count_next = running_count_reg;
        latched_count_next = latched_count_reg;
        was_in_zone_next   = was_in_zone_reg;
        prev_bearing_next  = prev_bearing_reg;
        out_count_next     = out_count_reg;
        out_updated_next   = out_updated_reg;
        out_valid_next     = out_valid_reg && !m_tready;
        if (clear) begin
            running_count_next = '0;
            latched_count_next = rgz_pkg::BOGEY_NONE;
            was_in_zone_next   = 1'b0;
            prev_bearing_next  = '0;
        end else if (fire) begin
            running_count_next = sat_count;
            if (s1.eos) begin
                out_updated_next = 1'b0;
                if (was_in_zone_reg && !active) begin
                    latched_count_next = {1'b0, sat_count};
                    running_count_next = '0;
                    out_updated_next   = 1'b1;
                end
                was_in_zone_next  = active;
                prev_bearing_next = s1.bearing;
                out_count_next    = latched_count_next;
                out_valid_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_count_reg <= '0;
            latched_count_reg <= rgz_pkg::BOGEY_NONE;
            was_in_zone_reg   <= 1'b0;
            prev_bearing_reg  <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            running_count_reg <= running_count_next;
            latched_count_reg <= latched_count_next;
            was_in_zone_reg   <= was_in_zone_next;
            prev_bearing_reg  <= prev_bearing_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_count_reg   <= out_count_next;
        out_updated_reg <= out_updated_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rgz_pkg::M_TDATA_W'(out_count_reg);
    assign m_tuser  = out_updated_reg;

    // a freshly latched count came from the 21-bit running count
    `RGZ_ASSERT_NOW(a_latched_nonneg, out_valid_reg && out_updated_reg, !out_count_reg[rgz_pkg::BOGEY_W-1])
    `RGZ_ASSERT_NEXT(a_clear_state, clear, running_count_reg == '0 && latched_count_reg == rgz_pkg::BOGEY_NONE && !was_in_zone_reg)
    `RGZ_ASSERT_NOW(a_result_source, $rose(out_valid_reg), $past(s1_valid && s1.eos && !clear))

endmodule
